// ----- rtl/core/sst_pkg.sv -----
// Shared types, codes and default sizes of the scoped symbol table.
package sst_pkg;

  // Default sizes
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned MAX_SCOPES_DEF    = 64;
  localparam int unsigned KEY_BITS_DEF      = 32;

  // Fixed field widths
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned KIND_W      = 8;
  localparam int unsigned TYPE_W      = 16;
  localparam int unsigned LOC_W       = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OUT_INDEX_W = 8;
  localparam int unsigned OUT_DEPTH_W = 6;

  // Stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH         = 3'd0,
    CMD_POP          = 3'd1,
    CMD_DEFINE       = 3'd2,
    CMD_LOOKUP_ALL   = 3'd3,
    CMD_LOOKUP_LOCAL = 3'd4
  } sst_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DEFINED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_SCOPE_ERR = 3'd4
  } sst_status_e;

  // Stored symbol attributes, location in the low bits
  typedef struct packed {
    logic              mutable_flag;
    logic [KIND_W-1:0] sym_kind;
    logic [TYPE_W-1:0] type_handle;
    logic [LOC_W-1:0]  source_location;
  } sst_payload_t;

  localparam int unsigned PAYLOAD_W = $bits(sst_payload_t);

  // Slave-side tdata layout, last field lowest
  typedef struct packed {
    logic [LOC_W-1:0]  source_location;
    logic              mutable_flag;
    logic [TYPE_W-1:0] type_handle;
    logic [KIND_W-1:0] sym_kind;
    logic [KEY_W-1:0]  key;
  } sst_in_t;

  // Master-side tdata layout, last field lowest
  typedef struct packed {
    logic [LOC_W-1:0]       found_location;
    logic                   found_mutable;
    logic [TYPE_W-1:0]      found_type;
    logic [KIND_W-1:0]      found_kind;
    logic [OUT_DEPTH_W-1:0] found_depth;
    logic [OUT_INDEX_W-1:0] entry_index;
  } sst_result_t;

endpackage

// ----- rtl/core/scoped_symbol_table.sv -----
// Top level of the scoped symbol table: command sequencer, scope stack and stream ports.
//
// Nested-scope symbol table. Each input transaction carries one command in
// s_axis_tuser (push scope, pop scope, define, lookup in all scopes, lookup
// in the current scope) and gives exactly one result transaction, whose
// status travels in m_axis_tuser. Entries live in a stack held in a
// synchronous key/attribute memory; each open scope remembers the entry
// index where it starts in a small scope-start memory. Define and both
// lookups scan the entry memory from the newest entry down to the lower
// bound of the search (entry zero, or the start of the current scope), one
// entry per cycle through the single read port, and stop at the first
// match. A define or lookup compares at most TABLE_ENTRIES entries and
// settles its result in the finish state, whether it stops on a match or
// runs down to the lower bound; push, pop, unknown commands and a define
// or lookup with nothing to compare go from acceptance straight to the
// finish state. The slave side takes the next command in the cycle after
// the result is loaded. One command is in flight at a time; a finished
// result waits in the output register, and the sequencer holds its next
// result until that register is free. Each entry records the scope depth
// it was defined at, so a hit reports its depth without walking the scope
// stack. Memories need no clearing after reset: only entries below the
// entry count are ever read. Keys compare on their low KEY_BITS bits.
module scoped_symbol_table #(
  parameter int unsigned TABLE_ENTRIES = sst_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_SCOPES    = sst_pkg::MAX_SCOPES_DEF,
  parameter int unsigned KEY_BITS      = sst_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command transactions
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key [31:0], sym_kind [39:32], type_handle [55:40], mutable_flag [56],
  // source_location [88:57], zero [95:89]
  input  logic [sst_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // command [2:0]
  input  logic [sst_pkg::CMD_W-1:0]      s_axis_tuser,
  // result transactions
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // entry_index [7:0], found_depth [13:8], found_kind [21:14],
  // found_type [37:22], found_mutable [38], found_location [70:39], zero [71]
  output logic [sst_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status [2:0]
  output logic [sst_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import sst_pkg::*;

  localparam int unsigned IW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned DW   = $clog2(MAX_SCOPES);
  localparam int unsigned KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned PW   = PAYLOAD_W + DW;
  localparam logic [CW-1:0] COUNT_FULL  = CW'(TABLE_ENTRIES);
  localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_SCOPES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e        state_q, state_d;
  sst_cmd_e      cmd_q;
  logic [KW-1:0] key_q;
  sst_payload_t  pay_q;
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [CW-1:0] cur_start_q, cur_start_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [IW-1:0] scan_q, scan_d;
  logic          issue_q, issue_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] rd_idx_q;

  logic          out_valid_q, out_valid_d;
  sst_status_e   out_status_q, status_d;
  sst_result_t   out_res_q, res_d;

  sst_in_t       in_fields;
  logic          in_accept;
  logic          fin_go;

  // entry store
  logic          st_we, st_re, st_rvalid, st_hit;
  logic [PW-1:0] st_rpay;
  sst_payload_t  hit_pay;
  logic [DW-1:0] hit_depth;

  // scope-start memory
  logic [CW-1:0] starts_mem [MAX_SCOPES];
  logic [CW-1:0] starts_rd_q;
  logic          sc_we, sc_re;
  logic [DW-1:0] sc_waddr;

  assign in_fields     = sst_in_t'(s_axis_tdata[$bits(sst_in_t)-1:0]);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  assign hit_pay   = sst_payload_t'(st_rpay[PAYLOAD_W-1:0]);
  assign hit_depth = st_rpay[PW-1:PAYLOAD_W];

  // Read the enclosing scope's start on a pop; it is held in starts_rd_q and used when the pop completes.
  assign sc_re    = in_accept && (sst_cmd_e'(s_axis_tuser) == CMD_POP);
  assign st_re    = (state_q == S_SCAN) && issue_q && !st_hit;

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      starts_mem[sc_waddr] <= count_q;
    end
    if (sc_re) begin
      starts_rd_q <= starts_mem[depth_q - 1'b1];
    end
  end

  sst_entry_store #(
    .Depth (TABLE_ENTRIES),
    .KeyW  (KW),
    .PayW  (PW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (st_we),
    .waddr_i   (count_q[IW-1:0]),
    .wkey_i    (key_q),
    .wpay_i    ({depth_q, pay_q}),
    .re_i      (st_re),
    .raddr_i   (scan_q),
    .cmp_key_i (key_q),
    .rvalid_o  (st_rvalid),
    .hit_o     (st_hit),
    .rpay_o    (st_rpay)
  );

  // Sequencer: accept, scan the entry stack for defines and lookups, then settle the result.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    depth_d     = depth_q;
    cur_start_d = cur_start_q;
    lo_d        = lo_q;
    scan_d      = scan_q;
    issue_d     = issue_q;
    hit_d       = hit_q;
    st_we       = 1'b0;
    sc_we       = 1'b0;
    sc_waddr    = depth_q + 1'b1;
    status_d    = ST_OK;
    res_d       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          hit_d = 1'b0;
          lo_d  = (sst_cmd_e'(s_axis_tuser) == CMD_LOOKUP_ALL) ? '0 : cur_start_q;
          if ((sst_cmd_e'(s_axis_tuser) == CMD_DEFINE ||
               sst_cmd_e'(s_axis_tuser) == CMD_LOOKUP_ALL ||
               sst_cmd_e'(s_axis_tuser) == CMD_LOOKUP_LOCAL) && (count_q > lo_d)) begin
            scan_d  = IW'(count_q - 1'b1);
            issue_d = 1'b1;
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (st_re) begin
          // advance toward the lower bound, stop after it
          if (scan_q == lo_q[IW-1:0]) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q - 1'b1;
          end
        end
        if (st_hit) begin
          hit_d   = 1'b1;
          issue_d = 1'b0;
          state_d = S_FIN;
        end else if (!issue_q && !st_rvalid) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        unique case (cmd_q)
          CMD_PUSH: begin
            if (depth_q >= DEPTH_LIMIT) begin
              status_d          = ST_SCOPE_ERR;
              res_d.found_depth = OUT_DEPTH_W'(depth_q);
            end else begin
              res_d.found_depth = OUT_DEPTH_W'(depth_q + 1'b1);
              if (fin_go) begin
                sc_we       = 1'b1;
                depth_d     = depth_q + 1'b1;
                cur_start_d = count_q;
              end
            end
          end
          CMD_POP: begin
            if (depth_q == '0) begin
              status_d = ST_SCOPE_ERR;
            end else begin
              res_d.found_depth = OUT_DEPTH_W'(depth_q - 1'b1);
              if (fin_go) begin
                count_d     = cur_start_q;
                depth_d     = depth_q - 1'b1;
                // global scope starts at entry zero
                cur_start_d = (depth_q == DW'(1)) ? '0 : starts_rd_q;
              end
            end
          end
          CMD_DEFINE, CMD_LOOKUP_ALL, CMD_LOOKUP_LOCAL: begin
            if (hit_q) begin
              status_d              = (cmd_q == CMD_DEFINE) ? ST_DEFINED : ST_OK;
              res_d.entry_index     = OUT_INDEX_W'(rd_idx_q);
              res_d.found_depth     = OUT_DEPTH_W'(hit_depth);
              res_d.found_kind      = hit_pay.sym_kind;
              res_d.found_type      = hit_pay.type_handle;
              res_d.found_mutable   = hit_pay.mutable_flag;
              res_d.found_location  = hit_pay.source_location;
            end else if (cmd_q != CMD_DEFINE) begin
              status_d = ST_NOT_FOUND;
            end else if (count_q == COUNT_FULL) begin
              status_d = ST_FULL;
            end else begin
              res_d.entry_index    = OUT_INDEX_W'(count_q);
              res_d.found_depth    = OUT_DEPTH_W'(depth_q);
              res_d.found_kind     = pay_q.sym_kind;
              res_d.found_type     = pay_q.type_handle;
              res_d.found_mutable  = pay_q.mutable_flag;
              res_d.found_location = pay_q.source_location;
              if (fin_go) begin
                st_we   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
          end
          default: begin
            res_d.found_depth = OUT_DEPTH_W'(depth_q);
          end
        endcase
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register: load on completion, drop when taken.
  always_comb begin
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      depth_q     <= '0;
      cur_start_q <= '0;
      lo_q        <= '0;
      scan_q      <= '0;
      issue_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      depth_q     <= depth_d;
      cur_start_q <= cur_start_d;
      lo_q        <= lo_d;
      scan_q      <= scan_d;
      issue_q     <= issue_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: command fields, read index, result.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= sst_cmd_e'(s_axis_tuser);
      key_q <= in_fields.key[KW-1:0];
      pay_q <= '{mutable_flag:    in_fields.mutable_flag,
                 sym_kind:        in_fields.sym_kind,
                 type_handle:     in_fields.type_handle,
                 source_location: in_fields.source_location};
    end
    if (st_re) begin
      rd_idx_q <= scan_q;
    end
    if (fin_go) begin
      out_status_q <= status_d;
      out_res_q    <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W - $bits(sst_result_t)){1'b0}}, out_res_q};
endmodule

// ----- rtl/core/sst_entry_store.sv -----
// Entry memories (keys and attributes) with a registered read and key match.
module sst_entry_store #(
  parameter int unsigned Depth = sst_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KeyW  = sst_pkg::KEY_BITS_DEF,
  parameter int unsigned PayW  = sst_pkg::PAYLOAD_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [KeyW-1:0]          wkey_i,
  input  logic [PayW-1:0]          wpay_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  input  logic [KeyW-1:0]          cmp_key_i,
  output logic                     rvalid_o,
  output logic                     hit_o,
  output logic [PayW-1:0]          rpay_o
);
  logic [KeyW-1:0] key_mem [Depth];
  logic [PayW-1:0] pay_mem [Depth];
  logic [KeyW-1:0] rkey_q;
  logic [PayW-1:0] rpay_q;
  logic            rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      pay_mem[waddr_i] <= wpay_i;
    end
    if (re_i) begin
      rkey_q <= key_mem[raddr_i];
      rpay_q <= pay_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= re_i;
    end
  end

  assign rvalid_o = rvalid_q;
  assign hit_o    = rvalid_q && (rkey_q == cmp_key_i);
  assign rpay_o   = rpay_q;
endmodule

// ----- rtl/core/sst_checker.sv -----
// Port-level checks of the scoped symbol table, bound to the top level.
module sst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sst_pkg::CMD_W-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sst_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [sst_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import sst_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One command at a time: no new transaction right after one is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a command while one is in flight");

  // Misses and a full table report nothing but the status.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL)
      |-> m_axis_tdata == '0)
    else $error("miss or full result carries data");

  // Scope commands taken while the result side is free report only a depth.
  a_scope_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready) &&
      (s_axis_tuser == CMD_PUSH || s_axis_tuser == CMD_POP) |-> ##2
      m_axis_tvalid && m_axis_tdata[OUT_INDEX_W-1:0] == '0 &&
      m_axis_tdata[M_TDATA_W-1:OUT_INDEX_W+OUT_DEPTH_W] == '0 &&
      (m_axis_tuser == ST_OK || m_axis_tuser == ST_SCOPE_ERR))
    else $error("scope command result carries entry data");
endmodule

bind scoped_symbol_table sst_checker u_sst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
